>>> rtl/dual_event_counter_status_led_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the dual event counter status lamp
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DUAL_EVENT_COUNTER_STATUS_LED_ASSERT_SVH
`define DUAL_EVENT_COUNTER_STATUS_LED_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every edge
`define DECSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DECSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DECSL_ASSERT(lbl, prop, msg)
`define DECSL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/decsl_pkg.sv
// ---------------------------------------------------------------------------
// decsl_pkg
// Types and constants shared by the dual event counter status lamp.
// ---------------------------------------------------------------------------
package decsl_pkg;

  localparam int CNT_W  = 14;
  localparam int PH_W   = 12;
  localparam int DIG_W  = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(9999);
  localparam logic [DIG_W-1:0] DIGIT_MAX   = DIG_W'(9);

  localparam logic [CNT_W-1:0] COUNT_MAX_RST   = CNT_W'(9999);
  localparam logic [PH_W-1:0]  FAST_PERIOD_RST = PH_W'(1000);
  localparam logic [PH_W-1:0]  SLOW_PERIOD_RST = PH_W'(2000);
  localparam logic [PH_W-1:0]  ON_TICKS_RST    = PH_W'(500);

  typedef enum logic [1:0] {
    REG_COUNT_MAX   = 2'd0,
    REG_FAST_PERIOD = 2'd1,
    REG_SLOW_PERIOD = 2'd2,
    REG_ON_TICKS    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] count_max;
    logic [PH_W-1:0]  fast_period;
    logic [PH_W-1:0]  slow_period;
    logic [PH_W-1:0]  on_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DIG_W-1:0] thousands;
    logic [DIG_W-1:0] hundreds;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] units;
  } digits_t;

  // binary count carried alongside its BCD digits
  typedef struct packed {
    logic [CNT_W-1:0] value;
    digits_t          digits;
  } cnt_t;

  typedef struct packed {
    logic action;
    logic count_a_active;
    logic count_b_active;
    logic clear_a_active;
    logic clear_b_active;
  } item_t;

endpackage

>>> rtl/dual_event_counter_status_led.sv
// ---------------------------------------------------------------------------
// dual_event_counter_status_led
// Two product counters with BCD digits and a blinking status lamp.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one request per item, action 0 is a
// timer tick, action 1 a pin event with four active levels.
// Output channel (out_valid / out_stall): one result per request with the
// lamp level, both counts and their decimal digits.
// A request is taken into an input register, updated against the counter and
// phase state when it moves on from that register, and written to the output
// register. One request per cycle is sustained while out_stall is low; the
// state update is a single add and compare per counter.
// A stalled result holds in the output register while the input register
// still takes one more request; in_stall rises only when both are full.
// Reset (rst, synchronous) empties both registers, clears counts, phases and
// lamp, and loads the configuration defaults. Configuration is written over
// the APB-style port at byte address 4 * index, pready always high.
// ---------------------------------------------------------------------------
module dual_event_counter_status_led (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [decsl_pkg::ADDR_W-1:0] paddr,
  input  logic [decsl_pkg::DATA_W-1:0] pwdata,
  output logic [decsl_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic                         count_a_active,
  input  logic                         count_b_active,
  input  logic                         clear_a_active,
  input  logic                         clear_b_active,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         lamp,
  output logic [decsl_pkg::CNT_W-1:0]  total_a,
  output logic [decsl_pkg::CNT_W-1:0]  total_b,
  output logic [decsl_pkg::DIG_W-1:0]  a_thousands,
  output logic [decsl_pkg::DIG_W-1:0]  a_hundreds,
  output logic [decsl_pkg::DIG_W-1:0]  a_tens,
  output logic [decsl_pkg::DIG_W-1:0]  a_units,
  output logic [decsl_pkg::DIG_W-1:0]  b_thousands,
  output logic [decsl_pkg::DIG_W-1:0]  b_hundreds,
  output logic [decsl_pkg::DIG_W-1:0]  b_tens,
  output logic [decsl_pkg::DIG_W-1:0]  b_units
);
  import decsl_pkg::*;

  `include "dual_event_counter_status_led_assert.svh"

  cfg_t  cfg;
  item_t item;
  logic  in_full;
  logic  advance;
  logic  step_evt, step_tick;
  cnt_t  cnt_a, cnt_a_next;
  cnt_t  cnt_b, cnt_b_next;
  logic  lamp_next;
  cnt_t  res_a, res_b;

  decsl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= '{action, count_a_active, count_b_active, clear_a_active, clear_b_active};
    end
  end

  assign step_evt  = advance && item.action;
  assign step_tick = advance && !item.action;

  decsl_counter u_cnt_a (
    .clk       (clk),
    .rst       (rst),
    .step      (step_evt),
    .inc       (item.count_a_active),
    .clr       (item.clear_a_active),
    .count_max (cfg.count_max),
    .cnt       (cnt_a),
    .cnt_next  (cnt_a_next)
  );

  decsl_counter u_cnt_b (
    .clk       (clk),
    .rst       (rst),
    .step      (step_evt),
    .inc       (item.count_b_active),
    .clr       (item.clear_b_active),
    .count_max (cfg.count_max),
    .cnt       (cnt_b),
    .cnt_next  (cnt_b_next)
  );

  // counts do not move on a tick, so the lamp compares the held values
  decsl_lamp u_lamp (
    .clk       (clk),
    .rst       (rst),
    .tick      (step_tick),
    .cfg       (cfg),
    .count_a   (cnt_a.value),
    .count_b   (cnt_b.value),
    .lamp_next (lamp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lamp  <= lamp_next;
      res_a <= cnt_a_next;
      res_b <= cnt_b_next;
    end
  end

  assign total_a     = res_a.value;
  assign a_thousands = res_a.digits.thousands;
  assign a_hundreds  = res_a.digits.hundreds;
  assign a_tens      = res_a.digits.tens;
  assign a_units     = res_a.digits.units;
  assign total_b     = res_b.value;
  assign b_thousands = res_b.digits.thousands;
  assign b_hundreds  = res_b.digits.hundreds;
  assign b_tens      = res_b.digits.tens;
  assign b_units     = res_b.digits.units;

  `DECSL_ASSERT(a_count_range, !out_valid || ((total_a <= COUNT_LIMIT) && (total_b <= COUNT_LIMIT)), "count above four digits")
  `DECSL_ASSERT(a_bcd_a_track, !out_valid || (int'(total_a) == int'(a_thousands) * 1000 + int'(a_hundreds) * 100 + int'(a_tens) * 10 + int'(a_units)), "digits of A disagree with count")
  `DECSL_ASSERT(a_bcd_b_track, !out_valid || (int'(total_b) == int'(b_thousands) * 1000 + int'(b_hundreds) * 100 + int'(b_tens) * 10 + int'(b_units)), "digits of B disagree with count")
  `DECSL_ASSERT_NEXT(a_lamp_zero, step_tick && (cnt_a.value == '0) && (cnt_b.value == '0), !lamp, "lamp lit with both counts zero")
  `DECSL_ASSERT(a_stall_full, !in_stall || in_full, "input stalled with an empty register")

endmodule

>>> rtl/decsl_regs.sv
// ---------------------------------------------------------------------------
// decsl_regs
// APB-style configuration registers: count limit, blink periods, lit ticks.
// ---------------------------------------------------------------------------
module decsl_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [decsl_pkg::ADDR_W-1:0] paddr,
  input  logic [decsl_pkg::DATA_W-1:0] pwdata,
  output logic [decsl_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output decsl_pkg::cfg_t              cfg
);
  import decsl_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_max   <= COUNT_MAX_RST;
      cfg.fast_period <= FAST_PERIOD_RST;
      cfg.slow_period <= SLOW_PERIOD_RST;
      cfg.on_ticks    <= ON_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_COUNT_MAX:   cfg.count_max   <= pwdata[CNT_W-1:0];
        REG_FAST_PERIOD: cfg.fast_period <= pwdata[PH_W-1:0];
        REG_SLOW_PERIOD: cfg.slow_period <= pwdata[PH_W-1:0];
        REG_ON_TICKS:    cfg.on_ticks    <= pwdata[PH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COUNT_MAX:   prdata = {{(DATA_W-CNT_W){1'b0}}, cfg.count_max};
      REG_FAST_PERIOD: prdata = {{(DATA_W-PH_W){1'b0}}, cfg.fast_period};
      REG_SLOW_PERIOD: prdata = {{(DATA_W-PH_W){1'b0}}, cfg.slow_period};
      REG_ON_TICKS:    prdata = {{(DATA_W-PH_W){1'b0}}, cfg.on_ticks};
    endcase
  end

endmodule

>>> rtl/decsl_counter.sv
// ---------------------------------------------------------------------------
// decsl_counter
// Product counter kept both in binary and as four BCD digits.
// ---------------------------------------------------------------------------
module decsl_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        inc,
  input  logic                        clr,
  input  logic [decsl_pkg::CNT_W-1:0] count_max,
  output decsl_pkg::cnt_t             cnt,
  output decsl_pkg::cnt_t             cnt_next
);
  import decsl_pkg::*;

  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] inc_val;
  digits_t          inc_dig;

  assign lim     = (count_max > COUNT_LIMIT) ? COUNT_LIMIT : count_max;
  assign inc_val = cnt.value + CNT_W'(1);

  // count never exceeds the limit, so the thousands digit cannot overflow
  always_comb begin
    inc_dig = cnt.digits;
    if (cnt.digits.units != DIGIT_MAX) begin
      inc_dig.units = cnt.digits.units + DIG_W'(1);
    end else begin
      inc_dig.units = '0;
      if (cnt.digits.tens != DIGIT_MAX) begin
        inc_dig.tens = cnt.digits.tens + DIG_W'(1);
      end else begin
        inc_dig.tens = '0;
        if (cnt.digits.hundreds != DIGIT_MAX) begin
          inc_dig.hundreds = cnt.digits.hundreds + DIG_W'(1);
        end else begin
          inc_dig.hundreds  = '0;
          inc_dig.thousands = cnt.digits.thousands + DIG_W'(1);
        end
      end
    end
  end

  // clear wins over the increment of the same event
  always_comb begin
    cnt_next = cnt;
    if (step) begin
      if (inc) begin
        if (inc_val > lim) begin
          cnt_next = '0;
        end else begin
          cnt_next.value  = inc_val;
          cnt_next.digits = inc_dig;
        end
      end
      if (clr) begin
        cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

>>> rtl/decsl_lamp.sv
// ---------------------------------------------------------------------------
// decsl_lamp
// Fast and slow blink phases and the status lamp level, advanced on ticks.
// ---------------------------------------------------------------------------
module decsl_lamp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  decsl_pkg::cfg_t             cfg,
  input  logic [decsl_pkg::CNT_W-1:0] count_a,
  input  logic [decsl_pkg::CNT_W-1:0] count_b,
  output logic                        lamp_next
);
  import decsl_pkg::*;

  logic [PH_W-1:0] fast_phase, fast_phase_next, fast_inc;
  logic [PH_W-1:0] slow_phase, slow_phase_next, slow_inc;
  logic            lamp_level;
  logic            lamp_tick;

  assign fast_inc = fast_phase + PH_W'(1);
  assign slow_inc = slow_phase + PH_W'(1);

  always_comb begin
    fast_phase_next = fast_phase;
    slow_phase_next = slow_phase;
    if (tick) begin
      fast_phase_next = (fast_inc >= cfg.fast_period) ? '0 : fast_inc;
      slow_phase_next = (slow_inc >= cfg.slow_period) ? '0 : slow_inc;
    end
  end

  always_comb begin
    priority if (count_a == count_b) begin
      lamp_tick = (count_a != '0);
    end else if (count_a < count_b) begin
      lamp_tick = (fast_phase_next < cfg.on_ticks);
    end else begin
      lamp_tick = (slow_phase_next < cfg.on_ticks);
    end
  end

  assign lamp_next = tick ? lamp_tick : lamp_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_phase <= '0;
      slow_phase <= '0;
      lamp_level <= 1'b0;
    end else begin
      fast_phase <= fast_phase_next;
      slow_phase <= slow_phase_next;
      lamp_level <= lamp_next;
    end
  end

endmodule

>>> tb/tb_dual_event_counter_status_led.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dual_event_counter_status_led
// Drives ticks and pin events into the dual event counter and checks every
// result (lamp, both counts, all eight digits) against a predictor kept in
// step with each accepted request, over several register settings and with
// random idling on both channels.
// ---------------------------------------------------------------------------
module tb_dual_event_counter_status_led;
  import decsl_pkg::*;

  localparam logic ACT_TICK      = 1'b0;
  localparam logic ACT_PIN_EVENT = 1'b1;

  typedef struct packed {
    logic             lamp;
    logic [CNT_W-1:0] total_a;
    logic [CNT_W-1:0] total_b;
    digits_t          a_digits;
    digits_t          b_digits;
  } display_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [DATA_W-1:0] pwdata         = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              action         = 1'b0;
  logic              count_a_active = 1'b0;
  logic              count_b_active = 1'b0;
  logic              clear_a_active = 1'b0;
  logic              clear_b_active = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              lamp;
  logic [CNT_W-1:0]  total_a;
  logic [CNT_W-1:0]  total_b;
  logic [DIG_W-1:0]  a_thousands;
  logic [DIG_W-1:0]  a_hundreds;
  logic [DIG_W-1:0]  a_tens;
  logic [DIG_W-1:0]  a_units;
  logic [DIG_W-1:0]  b_thousands;
  logic [DIG_W-1:0]  b_hundreds;
  logic [DIG_W-1:0]  b_tens;
  logic [DIG_W-1:0]  b_units;

  dual_event_counter_status_led u_top (.*);

  always #1 clk = ~clk;

  // predictor state and register shadow
  cfg_t             cfg_model = '{COUNT_MAX_RST, FAST_PERIOD_RST, SLOW_PERIOD_RST,
                                  ON_TICKS_RST};
  logic [CNT_W-1:0] model_a    = '0;
  logic [CNT_W-1:0] model_b    = '0;
  logic [PH_W-1:0]  model_fast = '0;
  logic [PH_W-1:0]  model_slow = '0;
  logic             model_lamp = 1'b0;

  display_t pending_displays[$];
  display_t seen;
  display_t want;
  int       fail_count   = 0;
  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  int       hold_len     = 0;

  function automatic logic [CNT_W-1:0] bumped_count(input logic [CNT_W-1:0] c);
    int ceiling;
    ceiling = (cfg_model.count_max > COUNT_LIMIT) ? COUNT_LIMIT : cfg_model.count_max;
    return (c + 1 > ceiling) ? '0 : CNT_W'(c + 1);
  endfunction

  function automatic logic [PH_W-1:0] bumped_phase(input logic [PH_W-1:0] p,
                                                   input logic [PH_W-1:0] period);
    logic [PH_W-1:0] n;
    n = p + 1'b1;
    return (n >= period) ? '0 : n;
  endfunction

  function automatic digits_t to_digits(input logic [CNT_W-1:0] v);
    digits_t g;
    g.thousands = DIG_W'(v / 1000);
    g.hundreds  = DIG_W'((v % 1000) / 100);
    g.tens      = DIG_W'((v % 100) / 10);
    g.units     = DIG_W'(v % 10);
    return g;
  endfunction

  function automatic display_t next_display(input item_t it);
    display_t d;
    if (it.action == ACT_PIN_EVENT) begin
      // clears win over the increments of the same event
      if (it.count_a_active) model_a = bumped_count(model_a);
      if (it.count_b_active) model_b = bumped_count(model_b);
      if (it.clear_a_active) model_a = '0;
      if (it.clear_b_active) model_b = '0;
    end else begin
      model_fast = bumped_phase(model_fast, cfg_model.fast_period);
      model_slow = bumped_phase(model_slow, cfg_model.slow_period);
      if (model_a == model_b) begin
        model_lamp = (model_a != '0);
      end else if (model_a < model_b) begin
        model_lamp = (model_fast < cfg_model.on_ticks);
      end else begin
        model_lamp = (model_slow < cfg_model.on_ticks);
      end
    end
    d.lamp     = model_lamp;
    d.total_a  = model_a;
    d.total_b  = model_b;
    d.a_digits = to_digits(model_a);
    d.b_digits = to_digits(model_b);
    return d;
  endfunction

  function automatic item_t random_request();
    item_t it;
    it.action         = ($urandom_range(99) < 55) ? ACT_PIN_EVENT : ACT_TICK;
    it.count_a_active = 1'($urandom_range(1));
    it.count_b_active = 1'($urandom_range(1));
    it.clear_a_active = ($urandom_range(99) < 6);
    it.clear_b_active = ($urandom_range(99) < 6);
    return it;
  endfunction

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  // called at a rising edge; returns at the edge where the request was taken
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= it.action;
    count_a_active <= it.count_a_active;
    count_b_active <= it.count_b_active;
    clear_a_active <= it.clear_a_active;
    clear_b_active <= it.clear_b_active;
    do @(posedge clk); while (in_stall);
    pending_displays.push_back(next_display(it));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COUNT_MAX:   cfg_model.count_max   = value[CNT_W-1:0];
      REG_FAST_PERIOD: cfg_model.fast_period = value[PH_W-1:0];
      REG_SLOW_PERIOD: cfg_model.slow_period = value[PH_W-1:0];
      REG_ON_TICKS:    cfg_model.on_ticks    = value[PH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_tick_and_event();
    send_gap_pct = 24;
    recv_gap_pct = 72;
    send_item(item_t'{ACT_TICK, 1'b1, 1'b1, 1'b1, 1'b1});      // fields ignored on a tick
    send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b0, 1'b0, 1'b0});
    send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});      // A ahead: slow blink
    send_item(item_t'{ACT_PIN_EVENT, 1'b0, 1'b1, 1'b0, 1'b0});
    send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});      // equal, lamp steady
    send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b1, 1'b1, 1'b1});
    send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});      // both zero, lamp off
    send_item(item_t'{ACT_PIN_EVENT, 1'b0, 1'b1, 1'b0, 1'b0});
    send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});      // B ahead: fast blink
    send_item(item_t'{ACT_PIN_EVENT, 1'b0, 1'b0, 1'b0, 1'b0});
    send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b0, 1'b1, 1'b0});
    settle();
  endtask

  task automatic test_count_limits();
    write_reg(REG_COUNT_MAX, 32'd3);
    repeat (5) send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b0, 1'b0, 1'b0});
    settle();
    write_reg(REG_COUNT_MAX, 32'd0);
    send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b1, 1'b0, 1'b0});
    settle();
  endtask

  task automatic test_blink_periods();
    write_reg(REG_COUNT_MAX, 32'd9999);
    write_reg(REG_FAST_PERIOD, 32'd0);
    write_reg(REG_SLOW_PERIOD, 32'd4095);
    write_reg(REG_ON_TICKS, 32'd1);
    send_item(item_t'{ACT_PIN_EVENT, 1'b0, 1'b1, 1'b0, 1'b0});
    repeat (2) send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});
    repeat (2) send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b0, 1'b0, 1'b0});
    repeat (2) send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});
    settle();
    // shrink the period under the running phase
    write_reg(REG_SLOW_PERIOD, 32'd2);
    repeat (2) send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});
    settle();
    write_reg(REG_ON_TICKS, 32'd0);
    send_item(item_t'{ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0});
    settle();
  endtask

  // runs both counters through tens and hundreds carries with the limit set
  // above the four-digit ceiling
  task automatic test_count_ceiling();
    item_t it;
    int    k;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_reg(REG_COUNT_MAX, 32'h3FFF);
    for (k = 0; k < 240; k++) begin
      it.action         = (k % 60 == 59) ? ACT_TICK : ACT_PIN_EVENT;
      it.count_a_active = 1'b1;
      it.count_b_active = (k >= 5);
      it.clear_a_active = 1'b0;
      it.clear_b_active = 1'b0;
      send_item(it);
    end
    settle();
    // limit under the current counts: next increment gives zero
    write_reg(REG_COUNT_MAX, 32'd5);
    send_item(item_t'{ACT_PIN_EVENT, 1'b1, 1'b0, 1'b0, 1'b0});
    send_item(item_t'{ACT_PIN_EVENT, 1'b0, 1'b1, 1'b0, 1'b0});
    settle();
  endtask

  task automatic test_input_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_len     = 40;
    repeat (30) send_item(random_request());
    settle();
  endtask

  task automatic test_random_mix(input int n, input int s_gap, input int r_gap);
    send_gap_pct = s_gap;
    recv_gap_pct = r_gap;
    repeat (n) send_item(random_request());
    settle();
  endtask

  // receiver stall; a long hold-off takes precedence over random idling
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len  = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.lamp                = lamp;
      seen.total_a             = total_a;
      seen.total_b             = total_b;
      seen.a_digits.thousands  = a_thousands;
      seen.a_digits.hundreds   = a_hundreds;
      seen.a_digits.tens       = a_tens;
      seen.a_digits.units      = a_units;
      seen.b_digits.thousands  = b_thousands;
      seen.b_digits.hundreds   = b_hundreds;
      seen.b_digits.tens       = b_tens;
      seen.b_digits.units      = b_units;
      if (pending_displays.size() == 0) begin
        log_failure($sformatf("result with no request outstanding: a %0d b %0d",
                              seen.total_a, seen.total_b));
      end else begin
        want = pending_displays.pop_front();
        if (seen !== want)
          log_failure($sformatf({"exp/got lamp %0b/%0b a %0d/%0d b %0d/%0d",
                                 " a digits %h/%h b digits %h/%h"},
                                want.lamp, seen.lamp, want.total_a, seen.total_a,
                                want.total_b, seen.total_b, want.a_digits,
                                seen.a_digits, want.b_digits, seen.b_digits));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_tick_and_event();
    test_count_limits();
    test_blink_periods();
    test_count_ceiling();
    test_input_backpressure();

    write_reg(REG_COUNT_MAX, $urandom_range(1, 12));
    write_reg(REG_FAST_PERIOD, $urandom_range(1, 8));
    write_reg(REG_SLOW_PERIOD, $urandom_range(1, 8));
    write_reg(REG_ON_TICKS, $urandom_range(0, 6));
    test_random_mix(350, 24, 72);

    write_reg(REG_COUNT_MAX, 32'd9999);
    write_reg(REG_FAST_PERIOD, 32'd4095);
    write_reg(REG_SLOW_PERIOD, 32'd1);
    write_reg(REG_ON_TICKS, 32'd4095);
    test_random_mix(350, 72, 24);

    write_reg(REG_COUNT_MAX, $urandom_range(0, 30));
    write_reg(REG_FAST_PERIOD, $urandom_range(0, 15));
    write_reg(REG_SLOW_PERIOD, $urandom_range(0, 15));
    write_reg(REG_ON_TICKS, $urandom_range(0, 15));
    test_random_mix(300, 0, 0);

    if (fail_count == 0 && pending_displays.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
